// ===== rtl/xie_pkg.sv =====
// ----------------------------------------------------------------------------
// xie_pkg
// Opcode ROM, operand codes and the descriptor passed from match to emit.
// ----------------------------------------------------------------------------
package xie_pkg;

  localparam logic [2:0] TY_NONE = 3'd0;
  localparam logic [2:0] TY_MRM  = 3'd2;
  localparam logic [2:0] TY_IMM  = 3'd3;
  localparam logic [2:0] TY_REL  = 3'd4;

  localparam logic [1:0] SZ_NONE = 2'd0;
  localparam logic [1:0] SZ_16   = 2'd2;
  localparam logic [1:0] SZ_32   = 2'd3;

  localparam logic [1:0] IW_1 = 2'd0;
  localparam logic [1:0] IW_2 = 2'd1;
  localparam logic [1:0] IW_4 = 2'd2;

  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_TWO    = 8'h0F;

  localparam int ROM_FILLED = 65;
  localparam int MATCH_LANES = 8;

  typedef struct packed {
    logic       filled;
    logic [5:0] mn;
    logic [7:0] pre;
    logic [7:0] op;
    logic [2:0] t0;
    logic [2:0] t1;
    logic [1:0] s0;
    logic [1:0] s1;
    logic [7:0] reg_bits;
  } rom_t;

  typedef struct packed {
    logic ok;
    logic swapped;
    logic rel;
  } match_t;

  typedef struct packed {
    logic        hit;
    logic        rel;
    logic        opsz;
    logic [7:0]  pre;
    logic [7:0]  op;
    logic [7:0]  modrm;
    logic [1:0]  immw;
    logic [4:0]  flags;
    logic [7:0]  sib;
    logic [31:0] disp;
    logic [31:0] imm;
    logic [7:0]  seg;
  } desc_t;

  function automatic rom_t mk(input logic [5:0] mn, input logic [7:0] pre,
                              input logic [7:0] op, input logic [2:0] t0,
                              input logic [2:0] t1, input logic [1:0] s0,
                              input logic [1:0] s1, input logic [7:0] rg);
    rom_t e;
    e.filled = 1'b1; e.mn = mn; e.pre = pre; e.op = op;
    e.t0 = t0; e.t1 = t1; e.s0 = s0; e.s1 = s1; e.reg_bits = rg;
    return e;
  endfunction

  function automatic rom_t rom_lookup(input logic [7:0] i);
    rom_t e;
    e = '0;
    case (i)
      8'd0:  e = mk(6'd0,  8'h00, 8'hC6, 3'd2, 3'd3, 2'd1, 2'd1, 8'h00);
      8'd1:  e = mk(6'd0,  8'h00, 8'hC7, 3'd2, 3'd3, 2'd3, 2'd3, 8'h00);
      8'd2:  e = mk(6'd0,  8'h00, 8'h88, 3'd2, 3'd1, 2'd1, 2'd1, 8'h00);
      8'd3:  e = mk(6'd0,  8'h00, 8'h89, 3'd2, 3'd1, 2'd3, 2'd3, 8'h00);
      8'd4:  e = mk(6'd1,  8'h00, 8'hFF, 3'd2, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd5:  e = mk(6'd2,  8'h00, 8'hFF, 3'd2, 3'd0, 2'd3, 2'd0, 8'h08);
      8'd6:  e = mk(6'd3,  8'h00, 8'hFF, 3'd2, 3'd0, 2'd3, 2'd0, 8'h10);
      8'd7:  e = mk(6'd4,  8'h00, 8'hFF, 3'd2, 3'd0, 2'd3, 2'd0, 8'h20);
      8'd8:  e = mk(6'd36, 8'h00, 8'hFF, 3'd2, 3'd0, 2'd3, 2'd0, 8'h30);
      8'd9:  e = mk(6'd3,  8'h00, 8'hE8, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd10: e = mk(6'd4,  8'h00, 8'hE9, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd11: e = mk(6'd5,  8'h0F, 8'h80, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd12: e = mk(6'd6,  8'h0F, 8'h81, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd13: e = mk(6'd7,  8'h0F, 8'h82, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd14: e = mk(6'd8,  8'h0F, 8'h82, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd15: e = mk(6'd9,  8'h0F, 8'h82, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd16: e = mk(6'd10, 8'h0F, 8'h83, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd17: e = mk(6'd11, 8'h0F, 8'h83, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd18: e = mk(6'd12, 8'h0F, 8'h83, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd19: e = mk(6'd13, 8'h0F, 8'h84, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd20: e = mk(6'd14, 8'h0F, 8'h84, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd21: e = mk(6'd15, 8'h0F, 8'h85, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd22: e = mk(6'd16, 8'h0F, 8'h85, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd23: e = mk(6'd17, 8'h0F, 8'h86, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd24: e = mk(6'd18, 8'h0F, 8'h86, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd25: e = mk(6'd19, 8'h0F, 8'h87, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd26: e = mk(6'd20, 8'h0F, 8'h87, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd27: e = mk(6'd21, 8'h0F, 8'h88, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd28: e = mk(6'd22, 8'h0F, 8'h89, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd29: e = mk(6'd23, 8'h0F, 8'h8A, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd30: e = mk(6'd24, 8'h0F, 8'h8A, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd31: e = mk(6'd25, 8'h0F, 8'h8B, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd32: e = mk(6'd26, 8'h0F, 8'h8B, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd33: e = mk(6'd27, 8'h0F, 8'h8C, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd34: e = mk(6'd28, 8'h0F, 8'h8C, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd35: e = mk(6'd29, 8'h0F, 8'h8D, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd36: e = mk(6'd30, 8'h0F, 8'h8E, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd37: e = mk(6'd31, 8'h0F, 8'h8E, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd38: e = mk(6'd32, 8'h0F, 8'h8D, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd39: e = mk(6'd33, 8'h0F, 8'h8F, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd40: e = mk(6'd34, 8'h0F, 8'h8F, 3'd4, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd41: e = mk(6'd35, 8'h00, 8'hC3, 3'd0, 3'd0, 2'd0, 2'd0, 8'h00);
      8'd42: e = mk(6'd36, 8'h00, 8'h68, 3'd3, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd43: e = mk(6'd37, 8'h00, 8'h8F, 3'd2, 3'd0, 2'd3, 2'd0, 8'h00);
      8'd44: e = mk(6'd38, 8'h00, 8'hCD, 3'd3, 3'd0, 2'd1, 2'd0, 8'h00);
      8'd45: e = mk(6'd39, 8'h00, 8'hCC, 3'd3, 3'd0, 2'd1, 2'd0, 8'h00);
      8'd46: e = mk(6'd40, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h00);
      8'd47: e = mk(6'd41, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h08);
      8'd48: e = mk(6'd42, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h10);
      8'd49: e = mk(6'd43, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h18);
      8'd50: e = mk(6'd44, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h20);
      8'd51: e = mk(6'd45, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h28);
      8'd52: e = mk(6'd46, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h30);
      8'd53: e = mk(6'd47, 8'h00, 8'h80, 3'd2, 3'd3, 2'd1, 2'd1, 8'h38);
      8'd54: e = mk(6'd40, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h00);
      8'd55: e = mk(6'd41, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h08);
      8'd56: e = mk(6'd42, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h10);
      8'd57: e = mk(6'd43, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h18);
      8'd58: e = mk(6'd44, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h20);
      8'd59: e = mk(6'd45, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h28);
      8'd60: e = mk(6'd46, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h30);
      8'd61: e = mk(6'd47, 8'h00, 8'h81, 3'd2, 3'd3, 2'd3, 2'd3, 8'h38);
      8'd62: e = mk(6'd48, 8'h00, 8'h8D, 3'd1, 3'd2, 2'd3, 2'd0, 8'h00);
      8'd63: e = mk(6'd47, 8'h00, 8'h38, 3'd2, 3'd1, 2'd1, 2'd1, 8'h00);
      8'd64: e = mk(6'd47, 8'h00, 8'h39, 3'd2, 3'd1, 2'd3, 2'd3, 8'h00);
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic match_t entry_match(input rom_t e, input logic [5:0] mn,
                                         input logic [3:0][2:0] ty,
                                         input logic [3:0][1:0] sz);
    match_t m;
    logic [3:0][1:0] rs;
    logic sz_ok, exact;
    rs = {SZ_NONE, SZ_NONE, e.s1, e.s0};
    sz_ok = 1'b1;
    for (int s = 0; s < 4; s++) begin
      if (rs[s] != sz[s] && ty[s] != TY_IMM) sz_ok = 1'b0;
    end
    exact = e.t0 == ty[0] && e.t1 == ty[1] && ty[2] == TY_NONE && ty[3] == TY_NONE;
    m.swapped = e.t0 == TY_MRM && ty[1] == TY_MRM && e.t1 == ty[0];
    m.rel = e.t0 == TY_REL && ty[0] == TY_IMM && e.t1 == ty[1] &&
            ty[2] == TY_NONE && ty[3] == TY_NONE;
    m.ok = e.filled && sz_ok && e.mn == mn && (exact || m.swapped || m.rel);
    return m;
  endfunction

endpackage

// ===== rtl/xie_match.sv =====
// ----------------------------------------------------------------------------
// xie_match
// Accepts instructions and scans the opcode ROM eight entries a cycle.
// ----------------------------------------------------------------------------
module xie_match import xie_pkg::*; #(
  parameter int TABLE_ENTRIES = 66,
  parameter int OPERAND_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  mnemonic_index,
  input  logic [11:0] operand_types,
  input  logic [7:0]  operand_sizes,
  input  logic [4:0]  present_flags,
  input  logic [7:0]  modrm_byte,
  input  logic [7:0]  sib_byte,
  input  logic [31:0] displacement,
  input  logic [31:0] immediate_value,
  input  logic [7:0]  segment_override,
  output logic        q_wr,
  input  logic        q_full,
  output desc_t       q_data
);

  localparam int CW = $clog2(TABLE_ENTRIES + MATCH_LANES + 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t           state;
  logic [CW-1:0]    idx;
  logic [5:0]       mn;
  logic [3:0][2:0]  ty;
  logic [3:0][1:0]  sz;
  logic             opsz;
  logic [4:0]       flags;
  logic [7:0]       modrm, sib, seg;
  logic [31:0]      disp, imm;

  logic [3:0][2:0]  ty_in;
  logic [3:0][1:0]  sz_in;
  logic             opsz_in;
  rom_t             pick_e;
  match_t           pick_m;
  logic             found, done;
  logic [CW-1:0]    cand;
  rom_t             lane_e;
  match_t           lane_m;
  logic [3:0][1:0]  rs;
  logic [1:0]       immw;
  logic             imm_seen;

  always_comb begin
    opsz_in = 1'b0;
    for (int s = 0; s < 4; s++) begin
      ty_in[s] = (s < OPERAND_SLOTS) ? operand_types[3*s +: 3] : TY_NONE;
      sz_in[s] = (s < OPERAND_SLOTS) ? operand_sizes[2*s +: 2] : SZ_NONE;
      if (sz_in[s] == SZ_16) opsz_in = 1'b1;
    end
    for (int s = 0; s < 4; s++) begin
      if (opsz_in && sz_in[s] == SZ_16) sz_in[s] = SZ_32;
    end
  end

  always_comb begin
    found  = 1'b0;
    pick_e = '0;
    pick_m = '0;
    cand   = '0;
    lane_e = '0;
    lane_m = '0;
    for (int j = 0; j < MATCH_LANES; j++) begin
      cand   = idx + CW'(j);
      lane_e = rom_lookup(8'(cand));
      lane_m = entry_match(lane_e, mn, ty, sz);
      if (!found && cand < CW'(TABLE_ENTRIES) && lane_m.ok) begin
        found  = 1'b1;
        pick_e = lane_e;
        pick_m = lane_m;
      end
    end
    done = found || (idx + CW'(MATCH_LANES) >= CW'(TABLE_ENTRIES));

    rs = {SZ_NONE, SZ_NONE, pick_e.s1, pick_e.s0};
    immw = IW_1;
    imm_seen = 1'b0;
    for (int s = 0; s < 4; s++) begin
      if (!imm_seen && ty[s] == TY_IMM) begin
        imm_seen = 1'b1;
        immw = (rs[s] == SZ_32) ? IW_4 : (rs[s] == SZ_16) ? IW_2 : IW_1;
      end
    end

    q_data.hit   = found;
    q_data.rel   = pick_m.rel;
    q_data.opsz  = opsz;
    q_data.pre   = pick_e.pre;
    q_data.op    = pick_m.swapped ? (pick_e.op | 8'h02) : pick_e.op;
    q_data.modrm = modrm | pick_e.reg_bits;
    q_data.immw  = immw;
    q_data.flags = flags;
    q_data.sib   = sib;
    q_data.disp  = disp;
    q_data.imm   = imm;
    q_data.seg   = seg;
  end

  assign full = state != S_IDLE;
  assign q_wr = state == S_SCAN && done && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            state <= S_SCAN;
            idx   <= '0;
            mn    <= mnemonic_index;
            ty    <= ty_in;
            sz    <= sz_in;
            opsz  <= opsz_in;
            flags <= present_flags;
            modrm <= modrm_byte;
            sib   <= sib_byte;
            disp  <= displacement;
            imm   <= immediate_value;
            seg   <= segment_override;
          end
        end
        S_SCAN: begin
          if (q_wr) state <= S_IDLE;
          else if (!done) idx <= idx + CW'(MATCH_LANES);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/xie_queue.sv =====
// ----------------------------------------------------------------------------
// xie_queue
// Two-entry descriptor queue between match and emit.
// ----------------------------------------------------------------------------
module xie_queue import xie_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  desc_t wr_data,
  output logic  full,
  input  logic  rd,
  output desc_t rd_data,
  output logic  empty
);

  desc_t       slots [2];
  logic        wp, rp;
  logic [1:0]  count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        slots[wp] <= wr_data;
        wp <= ~wp;
      end
      if (rd && !empty) rp <= ~rp;
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

endmodule

// ===== rtl/xie_emit.sv =====
// ----------------------------------------------------------------------------
// xie_emit
// Rebases relative targets and emits each descriptor's bytes before the next.
// ----------------------------------------------------------------------------
module xie_emit import xie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        q_empty,
  output logic        q_rd,
  input  desc_t       q_data,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  code_byte,
  output logic        last_byte,
  output logic        status
);

  typedef enum logic [1:0] {B_IDLE, B_SUM, B_FIX, B_EMIT} state_t;

  state_t       state;
  desc_t        d;
  logic [13:0]  mask;
  logic [3:0]   len;
  logic [3:0]   ph;
  logic [31:0]  sum;
  logic [31:0]  code_base;
  logic [31:0]  write_position;
  logic         out_valid;

  logic [13:0]  mask_next;
  logic         d8;
  logic [7:0]   cur;
  logic         is_last;
  logic         slot_free;
  logic         fire;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign q_rd      = state == B_IDLE && !q_empty;
  assign fire      = state == B_EMIT && slot_free && (!d.hit || mask[ph]);

  always_comb begin
    d8 = q_data.flags[3] && !q_data.flags[2];
    mask_next[0]     = q_data.seg != 8'h00;
    mask_next[1]     = q_data.opsz;
    mask_next[2]     = q_data.pre != 8'h00;
    mask_next[3]     = 1'b1;
    mask_next[4]     = q_data.flags[0];
    mask_next[5]     = q_data.flags[1];
    mask_next[6]     = q_data.flags[2] || d8;
    mask_next[9:7]   = {3{q_data.flags[2]}};
    mask_next[10]    = q_data.flags[4];
    mask_next[11]    = q_data.flags[4] && q_data.immw != IW_1;
    mask_next[13:12] = {2{q_data.flags[4] && q_data.immw == IW_4}};
  end

  always_comb begin
    case (ph)
      4'd0:    cur = d.seg;
      4'd1:    cur = PFX_OPSIZE;
      4'd2:    cur = d.pre;
      4'd3:    cur = d.op;
      4'd4:    cur = d.modrm;
      4'd5:    cur = d.sib;
      4'd6:    cur = d.disp[7:0];
      4'd7:    cur = d.disp[15:8];
      4'd8:    cur = d.disp[23:16];
      4'd9:    cur = d.disp[31:24];
      4'd10:   cur = d.imm[7:0];
      4'd11:   cur = d.imm[15:8];
      4'd12:   cur = d.imm[23:16];
      4'd13:   cur = d.imm[31:24];
      default: cur = 8'h00;
    endcase
    is_last = ~|(mask >> (5'(ph) + 5'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      out_valid      <= 1'b0;
      code_base      <= '0;
      write_position <= '0;
      ph             <= '0;
    end else begin
      if (cfg_valid) code_base <= cfg_data;
      if (fire) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            d     <= q_data;
            mask  <= mask_next;
            len   <= 4'($countones(mask_next));
            ph    <= '0;
            state <= q_data.hit ? B_SUM : B_EMIT;
          end
        end
        B_SUM: begin
          sum   <= code_base + write_position;
          state <= B_FIX;
        end
        B_FIX: begin
          if (d.rel) d.imm <= d.imm - {28'h0, len} - sum;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (!d.hit) begin
            if (slot_free) begin
              code_byte <= 8'h00;
              last_byte <= 1'b1;
              status    <= 1'b1;
              state     <= B_IDLE;
            end
          end else if (!mask[ph]) begin
            ph <= ph + 4'd1;
          end else if (slot_free) begin
            code_byte <= cur;
            last_byte <= is_last;
            status    <= 1'b0;
            ph        <= ph + 4'd1;
            if (is_last) begin
              write_position <= write_position + {28'h0, len};
              state          <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/x86_instruction_encoder.sv =====
// ----------------------------------------------------------------------------
// x86_instruction_encoder
// Table-driven 32-bit x86 encoder: one instruction in, its code bytes out.
// ----------------------------------------------------------------------------
// Match scans the ROM in eight lanes and can take the next instruction while
// emit still works. Emit loads a descriptor, runs B_SUM and B_FIX, then steps
// byte slots to the last byte (<= 14); a miss skips straight to B_EMIT.
// Synchronous reset clears code_base and the write position to zero.
// ----------------------------------------------------------------------------
module x86_instruction_encoder import xie_pkg::*; #(
  parameter int TABLE_ENTRIES = 66,
  parameter int OPERAND_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  mnemonic_index,
  input  logic [11:0] operand_types,
  input  logic [7:0]  operand_sizes,
  input  logic [4:0]  present_flags,
  input  logic [7:0]  modrm_byte,
  input  logic [7:0]  sib_byte,
  input  logic [31:0] displacement,
  input  logic [31:0] immediate_value,
  input  logic [7:0]  segment_override,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  code_byte,
  output logic        last_byte,
  output logic        status
);

  logic  q_wr, q_full, q_rd, q_empty;
  desc_t q_in, q_out;

  xie_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .OPERAND_SLOTS (OPERAND_SLOTS)
  ) u_match (
    .clk, .rst, .push, .full,
    .mnemonic_index, .operand_types, .operand_sizes, .present_flags,
    .modrm_byte, .sib_byte, .displacement, .immediate_value, .segment_override,
    .q_wr, .q_full, .q_data (q_in)
  );

  xie_queue u_queue (
    .clk, .rst,
    .wr (q_wr), .wr_data (q_in), .full (q_full),
    .rd (q_rd), .rd_data (q_out), .empty (q_empty)
  );

  xie_emit u_emit (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .q_empty, .q_rd, .q_data (q_out),
    .empty, .pop, .code_byte, .last_byte, .status
  );

endmodule
